@@ rtl/tilc_pkg.sv @@
package tilc_pkg;

  // Coordinate width of each vertex field
  localparam int COORD_BITS    = 16;
  // Signed width of a vertex difference
  localparam int DIFF_BITS     = COORD_BITS + 1;
  // Width of a difference magnitude, also the width of an edge gcd
  localparam int MAG_BITS      = COORD_BITS;
  // Shift count width for the binary gcd's common factor of two
  localparam int SHIFT_BITS    = (MAG_BITS > 1) ? $clog2(MAG_BITS) : 1;
  // Signed product and cross product widths
  localparam int PROD_BITS     = 2 * DIFF_BITS;
  localparam int CROSS_BITS    = PROD_BITS + 1;
  // Sum of the gcds of edges ab, ac and cb
  localparam int BND_BITS      = MAG_BITS + 2;
  // Signed difference of area and boundary
  localparam int DELTA_BITS    = CROSS_BITS + 1;

  // Output field widths
  localparam int INTERIOR_BITS = 35;
  localparam int BOUNDARY_BITS = 19;
  localparam int AREA_BITS     = 35;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_CROSS,
    S_AREA,
    S_RUN,
    S_SUM,
    S_SUB,
    S_FIN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic load_diff;
    logic load_mul;
    logic load_cross;
    logic load_area;
    logic gcd_load;
    logic gcd_step;
    logic load_sum;
    logic load_sub;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic gcd_done;
  } status_t;

endpackage

@@ rtl/tilc_gcd.sv @@
module tilc_gcd (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          step,
  input  logic [tilc_pkg::MAG_BITS-1:0] a_in,
  input  logic [tilc_pkg::MAG_BITS-1:0] b_in,
  output logic                          done,
  output logic [tilc_pkg::MAG_BITS-1:0] result
);
  import tilc_pkg::*;

  logic [MAG_BITS-1:0]   a;
  logic [MAG_BITS-1:0]   b;
  logic [SHIFT_BITS-1:0] k;
  logic [MAG_BITS-1:0]   a_next;
  logic [MAG_BITS-1:0]   b_next;
  logic [SHIFT_BITS-1:0] k_next;
  logic [MAG_BITS-1:0]   a_sub_b;
  logic [MAG_BITS-1:0]   b_sub_a;

  // Finished once either operand reaches zero; the other, shifted left by k, is the gcd
  assign done    = (a == '0) || (b == '0);
  assign result  = (a | b) << k;
  assign a_sub_b = a - b;
  assign b_sub_a = b - a;

  // One binary gcd step: strip factors of two or subtract odd operands
  always_comb begin
    a_next = a;
    b_next = b;
    k_next = k;
    if (!done) begin
      if (!a[0] && !b[0]) begin
        a_next = a >> 1;
        b_next = b >> 1;
        k_next = k + SHIFT_BITS'(1);
      end else if (!a[0]) begin
        a_next = a >> 1;
      end else if (!b[0]) begin
        b_next = b >> 1;
      end else if (a >= b) begin
        a_next = a_sub_b >> 1;
      end else begin
        b_next = b_sub_a >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a <= a_in;
      b <= b_in;
      k <= '0;
    end else if (step) begin
      a <= a_next;
      b <= b_next;
      k <= k_next;
    end
  end

  // Operands never grow while stepping
  a_shrink: assert property (@(posedge clk) disable iff (rst)
    step && !load |=> (a <= $past(a)) && (b <= $past(b)))
    else $error("gcd operand grew during a step");

  // A finished unit keeps its answer
  done_hold: assert property (@(posedge clk) disable iff (rst)
    step && !load && done |=> done && $stable(result))
    else $error("gcd result changed after completion");

endmodule

@@ rtl/tilc_dp.sv @@
module tilc_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tilc_pkg::cmd_t                        cmd,
  output tilc_pkg::status_t                     status,
  input  logic signed [tilc_pkg::COORD_BITS-1:0] ax,
  input  logic signed [tilc_pkg::COORD_BITS-1:0] ay,
  input  logic signed [tilc_pkg::COORD_BITS-1:0] bx,
  input  logic signed [tilc_pkg::COORD_BITS-1:0] by_coord,
  input  logic signed [tilc_pkg::COORD_BITS-1:0] cx,
  input  logic signed [tilc_pkg::COORD_BITS-1:0] cy,
  output logic signed [tilc_pkg::INTERIOR_BITS-1:0] interior_count,
  output logic [tilc_pkg::BOUNDARY_BITS-1:0]    boundary_count,
  output logic [tilc_pkg::AREA_BITS-1:0]        double_area
);
  import tilc_pkg::*;

  // Captured vertices
  logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  // Edge differences
  logic signed [DIFF_BITS-1:0]  abx, aby, acx, acy, cbx, cby;
  // Cross product terms and results
  logic signed [PROD_BITS-1:0]  prod_a, prod_b;
  logic signed [CROSS_BITS-1:0] cross_prod;
  logic [CROSS_BITS-1:0]        area;
  logic [BND_BITS-1:0]          bnd;
  logic signed [DELTA_BITS-1:0] delta;
  logic signed [DELTA_BITS-1:0] inner_sum;
  logic signed [DELTA_BITS-1:0] inner;
  // Gcd unit connections
  logic [MAG_BITS-1:0]          mag_abx, mag_aby, mag_acx, mag_acy, mag_cbx, mag_cby;
  logic [MAG_BITS-1:0]          g_ab, g_ac, g_cb;
  logic                         done_ab, done_ac, done_cb;

  function automatic logic [MAG_BITS-1:0] mag_of(input logic signed [DIFF_BITS-1:0] v);
    logic signed [DIFF_BITS-1:0] neg;
    neg = -v;
    return v[DIFF_BITS-1] ? neg[MAG_BITS-1:0] : v[MAG_BITS-1:0];
  endfunction

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ax_q <= ax;
      ay_q <= ay;
      bx_q <= bx;
      by_q <= by_coord;
      cx_q <= cx;
      cy_q <= cy;
    end
  end

  // Edge differences
  always_ff @(posedge clk) begin
    if (cmd.load_diff) begin
      abx <= DIFF_BITS'(bx_q) - DIFF_BITS'(ax_q);
      aby <= DIFF_BITS'(by_q) - DIFF_BITS'(ay_q);
      acx <= DIFF_BITS'(cx_q) - DIFF_BITS'(ax_q);
      acy <= DIFF_BITS'(cy_q) - DIFF_BITS'(ay_q);
      cbx <= DIFF_BITS'(bx_q) - DIFF_BITS'(cx_q);
      cby <= DIFF_BITS'(by_q) - DIFF_BITS'(cy_q);
    end
  end

  assign mag_abx = mag_of(abx);
  assign mag_aby = mag_of(aby);
  assign mag_acx = mag_of(acx);
  assign mag_acy = mag_of(acy);
  assign mag_cbx = mag_of(cbx);
  assign mag_cby = mag_of(cby);

  // Two products, then their difference, then the magnitude
  always_ff @(posedge clk) begin
    if (cmd.load_mul) begin
      prod_a <= abx * acy;
      prod_b <= acx * aby;
    end
    if (cmd.load_cross) begin
      cross_prod <= CROSS_BITS'(prod_a) - CROSS_BITS'(prod_b);
    end
    if (cmd.load_area) begin
      area <= cross_prod[CROSS_BITS-1] ? CROSS_BITS'(-cross_prod) : CROSS_BITS'(cross_prod);
    end
  end

  // One gcd unit per edge, all stepped together
  tilc_gcd u_gcd_ab (
    .clk    (clk),
    .rst    (rst),
    .load   (cmd.gcd_load),
    .step   (cmd.gcd_step),
    .a_in   (mag_abx),
    .b_in   (mag_aby),
    .done   (done_ab),
    .result (g_ab)
  );

  tilc_gcd u_gcd_ac (
    .clk    (clk),
    .rst    (rst),
    .load   (cmd.gcd_load),
    .step   (cmd.gcd_step),
    .a_in   (mag_acx),
    .b_in   (mag_acy),
    .done   (done_ac),
    .result (g_ac)
  );

  tilc_gcd u_gcd_cb (
    .clk    (clk),
    .rst    (rst),
    .load   (cmd.gcd_load),
    .step   (cmd.gcd_step),
    .a_in   (mag_cbx),
    .b_in   (mag_cby),
    .done   (done_cb),
    .result (g_cb)
  );

  assign status.gcd_done = done_ab && done_ac && done_cb;

  // Boundary: each edge holds gcd+1 points, each vertex counted twice
  always_ff @(posedge clk) begin
    if (cmd.load_sum) begin
      bnd <= BND_BITS'(g_ab) + BND_BITS'(g_ac) + BND_BITS'(g_cb);
    end
    if (cmd.load_sub) begin
      delta <= DELTA_BITS'(area) - DELTA_BITS'(bnd);
    end
  end

  // Halve toward zero and add one: (delta + 2 or 3) arithmetic shift right
  assign inner_sum = delta + (delta[DELTA_BITS-1] ? DELTA_BITS'(3) : DELTA_BITS'(2));
  assign inner     = inner_sum >>> 1;

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      interior_count <= INTERIOR_BITS'(inner);
      boundary_count <= BOUNDARY_BITS'(bnd);
      double_area    <= AREA_BITS'(area);
    end
  end

endmodule

@@ rtl/tilc_ctrl.sv @@
module tilc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tilc_pkg::status_t   status,
  output tilc_pkg::cmd_t      cmd
);
  import tilc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   out_valid_next;

  // Output register can take a new item when empty or being drained
  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_DIFF;
      S_DIFF:  state_next = S_MUL;
      S_MUL:   state_next = S_CROSS;
      S_CROSS: state_next = S_AREA;
      S_AREA:  state_next = S_RUN;
      S_RUN:   if (status.gcd_done) state_next = S_SUM;
      S_SUM:   state_next = S_SUB;
      S_SUB:   state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_DIFF:  cmd.load_diff = 1'b1;
      S_MUL: begin
        cmd.load_mul = 1'b1;
        cmd.gcd_load = 1'b1;
      end
      S_CROSS: begin
        cmd.load_cross = 1'b1;
        cmd.gcd_step   = 1'b1;
      end
      S_AREA: begin
        cmd.load_area = 1'b1;
        cmd.gcd_step  = 1'b1;
      end
      S_RUN:   cmd.gcd_step = 1'b1;
      S_SUM:   cmd.load_sum = 1'b1;
      S_SUB:   cmd.load_sub = 1'b1;
      S_FIN:   cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // A pending result is never overwritten
  no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result register loaded while holding an untaken item");

  // Gcd units only start once per item, right after the differences
  gcd_start: assert property (@(posedge clk) disable iff (rst)
    cmd.gcd_load |-> $past(cmd.load_diff))
    else $error("gcd load without fresh differences");

endmodule

@@ rtl/triangle_interior_lattice_count.sv @@
// Counts lattice points strictly inside a triangle by Pick's theorem. An item
// holds three signed vertices; its result gives the doubled area A = |cross
// product|, the boundary count b (sum of the gcds of |dx|,|dy| over edges ab,
// ac and cb), and interior_count = (A - b)/2 truncated toward zero, plus one,
// which can be zero or negative for collinear vertices. One item is worked at
// a time: after acceptance come the differences, then the products while the
// gcd units load, then the cross product and its magnitude while the gcd steps
// begin, then the rest of the gcd loop, the boundary sum, the area minus
// boundary and the result register, which waits while an untaken result is
// held. The edge units step together. The gcd loop and the output wait set
// how long an item takes. A finished result waits in its own output register,
// so the next item may be accepted before it is taken.
module triangle_interior_lattice_count (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [tilc_pkg::COORD_BITS-1:0]    ax,
  input  logic signed [tilc_pkg::COORD_BITS-1:0]    ay,
  input  logic signed [tilc_pkg::COORD_BITS-1:0]    bx,
  input  logic signed [tilc_pkg::COORD_BITS-1:0]    by_coord,
  input  logic signed [tilc_pkg::COORD_BITS-1:0]    cx,
  input  logic signed [tilc_pkg::COORD_BITS-1:0]    cy,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [tilc_pkg::INTERIOR_BITS-1:0] interior_count,
  output logic [tilc_pkg::BOUNDARY_BITS-1:0]        boundary_count,
  output logic [tilc_pkg::AREA_BITS-1:0]            double_area
);
  import tilc_pkg::*;

  cmd_t    cmd;
  status_t status;

  tilc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tilc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .ax             (ax),
    .ay             (ay),
    .bx             (bx),
    .by_coord       (by_coord),
    .cx             (cx),
    .cy             (cy),
    .interior_count (interior_count),
    .boundary_count (boundary_count),
    .double_area    (double_area)
  );

  // An accepted item keeps the input side stalled while it is worked
  busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous item still in progress");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import tilc_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One triangle as offered to the block
  typedef struct {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by_coord;
    coord_t cx;
    coord_t cy;
  } tri_t;

  // One counted result
  typedef struct {
    logic signed [INTERIOR_BITS-1:0] interior;
    logic [BOUNDARY_BITS-1:0]        boundary;
    logic [AREA_BITS-1:0]            area;
  } counts_t;

  // Directed row: six coordinates, plus hand-computed counts where obvious
  typedef struct {
    int     c[6];
    bit     typed;
    longint in_cnt;
    longint b_cnt;
    longint a2;
  } row_t;

  localparam int N_DIR    = 20;
  localparam int N_RANDOM = 1500;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t ax = '0;
  coord_t ay = '0;
  coord_t bx = '0;
  coord_t by_coord = '0;
  coord_t cx = '0;
  coord_t cy = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic signed [INTERIOR_BITS-1:0] interior_count;
  logic [BOUNDARY_BITS-1:0]        boundary_count;
  logic [AREA_BITS-1:0]            double_area;

  counts_t expected_counts[$];
  int      mismatch_cnt = 0;
  int      sent_cnt = 0;
  bit      tx_burst = 1'b0;
  bit      rx_burst = 1'b0;

  // Corners, degenerate shapes, orientation, long diagonals
  row_t dir_rows [N_DIR] = '{
    '{'{0, 0, 0, 0, 0, 0}, 1'b1, 1, 0, 0},
    '{'{5, 5, 5, 5, 5, 5}, 1'b1, 1, 0, 0},
    '{'{0, 0, 1, 0, 0, 1}, 1'b1, 0, 3, 1},
    '{'{0, 0, 0, 1, 1, 0}, 1'b1, 0, 3, 1},
    '{'{0, 0, 2, 2, 4, 4}, 1'b1, -3, 8, 0},
    '{'{0, 0, 0, 0, 3, 0}, 1'b1, -2, 6, 0},
    '{'{0, 0, 4, 0, 0, 4}, 1'b1, 3, 12, 16},
    '{'{-32768, -32768, 32767, -32768, -32768, 32767}, 1'b0, 0, 0, 0},
    '{'{32767, 32767, -32768, 32767, 32767, -32768}, 1'b0, 0, 0, 0},
    '{'{-32768, -32768, 32767, 32767, 32767, -32768}, 1'b0, 0, 0, 0},
    '{'{-32768, -32768, -32768, -32768, -32768, -32768}, 1'b1, 1, 0, 0},
    '{'{32767, 32767, 32767, 32767, 32767, 32767}, 1'b1, 1, 0, 0},
    '{'{-32768, -32768, 32767, 32767, -32768, -32768}, 1'b0, 0, 0, 0},
    '{'{-32768, 32767, 32767, -32768, 0, 0}, 1'b0, 0, 0, 0},
    '{'{0, 0, 32767, 1, 1, 32767}, 1'b0, 0, 0, 0},
    '{'{0, 0, 16384, 0, 0, -32768}, 1'b0, 0, 0, 0},
    '{'{-1, -1, 0, 0, 1, 1}, 1'b1, -1, 4, 0},
    '{'{-1, 0, 0, -1, 1, 1}, 1'b0, 0, 0, 0},
    '{'{-21845, 21845, 21845, -21845, -32768, 32767}, 1'b0, 0, 0, 0},
    '{'{32767, -32768, -32768, 32767, 32767, 32767}, 1'b0, 0, 0, 0}
  };

  triangle_interior_lattice_count u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .ax             (ax),
    .ay             (ay),
    .bx             (bx),
    .by_coord       (by_coord),
    .cx             (cx),
    .cy             (cy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .interior_count (interior_count),
    .boundary_count (boundary_count),
    .double_area    (double_area)
  );

  always #5 clk = ~clk;

  // Euclid on magnitudes; gcd(0,0) is 0
  function automatic longint unsigned edge_gcd(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic longint unsigned span(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Pick's theorem: I = (A - b) / 2 + 1, truncated toward zero
  function automatic counts_t count_lattice(tri_t t);
    longint          x0, y0, x1, y1, x2, y2;
    longint          cross_val, inner;
    longint unsigned area2, bnd;
    counts_t         r;
    x0 = t.ax;
    y0 = t.ay;
    x1 = t.bx;
    y1 = t.by_coord;
    x2 = t.cx;
    y2 = t.cy;
    cross_val = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
    area2 = span(cross_val);
    // edge points minus the doubly counted vertices leaves the gcd sum
    bnd = edge_gcd(span(x1 - x0), span(y1 - y0))
        + edge_gcd(span(x2 - x0), span(y2 - y0))
        + edge_gcd(span(x1 - x2), span(y1 - y2));
    inner = (longint'(area2) - longint'(bnd)) / 2 + 1;
    r.interior = INTERIOR_BITS'(inner);
    r.boundary = BOUNDARY_BITS'(bnd);
    r.area     = AREA_BITS'(area2);
    return r;
  endfunction

  // Mix of shapes: full range, small boxes, collinear, even-heavy, shared vertices
  function automatic tri_t random_triangle();
    int   c[6];
    int   mode, base_x, base_y, dx, dy, k1, k2, sh, src, dst;
    int   picks[5];
    tri_t t;
    picks = '{-32768, 32767, 0, -1, 1};
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2, 3: begin
        foreach (c[k]) c[k] = int'($urandom);
      end
      4, 5: begin
        base_x = int'($urandom_range(0, 64000)) - 32000;
        base_y = int'($urandom_range(0, 64000)) - 32000;
        for (int k = 0; k < 3; k++) begin
          c[2*k]   = base_x + int'($urandom_range(0, 80)) - 40;
          c[2*k+1] = base_y + int'($urandom_range(0, 80)) - 40;
        end
      end
      6: begin
        base_x = int'($urandom_range(0, 2000)) - 1000;
        base_y = int'($urandom_range(0, 2000)) - 1000;
        dx = int'($urandom_range(0, 120)) - 60;
        dy = int'($urandom_range(0, 120)) - 60;
        k1 = int'($urandom_range(0, 400)) - 200;
        k2 = int'($urandom_range(0, 400)) - 200;
        c = '{base_x, base_y, base_x + k1 * dx, base_y + k1 * dy,
              base_x + k2 * dx, base_y + k2 * dy};
      end
      7: begin
        sh = $urandom_range(0, 15);
        foreach (c[k]) c[k] = int'($urandom_range(0, 65535)) << sh;
      end
      8: begin
        foreach (c[k]) c[k] = int'($urandom);
        src = $urandom_range(0, 2);
        dst = (src + 1 + int'($urandom_range(0, 1))) % 3;
        c[2*dst]   = c[2*src];
        c[2*dst+1] = c[2*src+1];
      end
      default: begin
        foreach (c[k])
          c[k] = ($urandom_range(0, 5) == 5) ? int'($urandom)
                                              : picks[$urandom_range(0, 4)];
      end
    endcase
    t.ax       = coord_t'(c[0]);
    t.ay       = coord_t'(c[1]);
    t.bx       = coord_t'(c[2]);
    t.by_coord = coord_t'(c[3]);
    t.cx       = coord_t'(c[4]);
    t.cy       = coord_t'(c[5]);
    return t;
  endfunction

  // Offer one item after a random gap, queue its counts once accepted
  task automatic offer_triangle(input tri_t t, input bit typed, input counts_t want);
    int gap;
    if (sent_cnt % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    gap = tx_burst ? 0 : int'($urandom_range(0, 13));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ax       <= t.ax;
    ay       <= t.ay;
    bx       <= t.bx;
    by_coord <= t.by_coord;
    cx       <= t.cx;
    cy       <= t.cy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_counts.push_back(typed ? want : count_lattice(t));
    sent_cnt++;
  endtask

  // Stimulus: reset, directed table, random items, drain
  initial begin : stim
    tri_t    t;
    counts_t want;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIR; i++) begin
      t.ax       = coord_t'(dir_rows[i].c[0]);
      t.ay       = coord_t'(dir_rows[i].c[1]);
      t.bx       = coord_t'(dir_rows[i].c[2]);
      t.by_coord = coord_t'(dir_rows[i].c[3]);
      t.cx       = coord_t'(dir_rows[i].c[4]);
      t.cy       = coord_t'(dir_rows[i].c[5]);
      want.interior = INTERIOR_BITS'(dir_rows[i].in_cnt);
      want.boundary = BOUNDARY_BITS'(dir_rows[i].b_cnt);
      want.area     = AREA_BITS'(dir_rows[i].a2);
      offer_triangle(t, dir_rows[i].typed, want);
    end
    for (int i = 0; i < N_RANDOM; i++) offer_triangle(random_triangle(), 1'b0, want);
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    // let any stray result show up
    repeat (60) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Result side stalls: random per item, bursts, one long hold to back up the block
  initial begin : drain
    int hold;
    int taken;
    taken = 0;
    wait (rst == 1'b0);
    forever begin
      if (taken % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      hold = rx_burst ? 0 : int'($urandom_range(0, 13));
      if (taken == 300) hold = 500;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Compare each taken result with the oldest queued counts
  always @(posedge clk) begin : check
    counts_t got;
    counts_t want;
    if (!rst && out_valid && !out_stall) begin
      got.interior = interior_count;
      got.boundary = boundary_count;
      got.area     = double_area;
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected item: interior %0d boundary %0d area %0d",
                 $time, got.interior, got.boundary, got.area);
        mismatch_cnt++;
      end else begin
        want = expected_counts.pop_front();
        if (got.interior !== want.interior) begin
          $display("%0t: interior_count expected %0d got %0d",
                   $time, want.interior, got.interior);
          mismatch_cnt++;
        end
        if (got.boundary !== want.boundary) begin
          $display("%0t: boundary_count expected %0d got %0d",
                   $time, want.boundary, got.boundary);
          mismatch_cnt++;
        end
        if (got.area !== want.area) begin
          $display("%0t: double_area expected %0d got %0d",
                   $time, want.area, got.area);
          mismatch_cnt++;
        end
      end
    end
  end

  // Hang guard, several times the slowest legal run
  initial begin : watchdog
    #6000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
